// File: design/satq_pkg.sv
`timescale 1ns / 1ps
package satq_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ADDR_W      = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH       = MAX_ROWS * MAX_COLS;
  localparam int CFG_W       = 7;
  localparam int IDX_W       = 1;
  localparam int ELEM_W      = 16;
  localparam int RS_W        = 22;
  localparam int SUM_W       = 28;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'd1;

  // result status codes
  localparam logic [1:0] STAT_STORED = 2'd0;
  localparam logic [1:0] STAT_DONE   = 2'd1;
  localparam logic [1:0] STAT_ANSWER = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REJECT = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ROWS_RST = 7'd4;
  localparam logic [CFG_W-1:0] CFG_COLS_RST = 7'd5;

  // Load: addr[0] is the entry above, addr[1] the entry written, use[0] marks
  // a real row above. Query: addr/use hold the four corners in the order
  // (b,r) (t-1,r) (b,l-1) (t-1,l-1); corners 1 and 2 (0-based) subtract.
  typedef struct packed {
    logic [1:0]                   kind;
    logic [1:0]                   status;
    logic [3:0]                   use_mask;
    logic [3:0][ADDR_W-1:0]       addr;
    logic signed [RS_W-1:0]       rsum;
  } cmd_t;

  // 0-based row and column to table address
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] c);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
    return a;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int max_v);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > CFG_W'(max_v)) begin
      res = CFG_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: design/satq_front.sv
`timescale 1ns / 1ps
module satq_front import satq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic [CFG_W-1:0]         in_top_row,
  input  logic [CFG_W-1:0]         in_left_col,
  input  logic [CFG_W-1:0]         in_bottom_row,
  input  logic [CFG_W-1:0]         in_right_col,
  input  logic                     q_full,
  output logic                     q_push,
  output cmd_t                     q_cmd
);

  logic [CFG_W-1:0]       rows_r, rows_nxt;
  logic [CFG_W-1:0]       cols_r, cols_nxt;
  logic [CFG_W-1:0]       load_row_r, load_row_nxt;
  logic [CFG_W-1:0]       load_col_r, load_col_nxt;
  logic signed [RS_W-1:0] rs_r, rs_nxt;
  logic                   done_r, done_nxt;

  logic [CFG_W-1:0]       row, col;
  logic signed [RS_W-1:0] rs_new;
  logic                   last_col, last_row;
  logic                   ok;
  logic [CFG_W-1:0]       tm1, lm1;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    rs_nxt       = rs_r;
    done_nxt     = done_r;
    q_cmd        = '0;

    // a finished table restarts at the first element
    row      = done_r ? '0 : load_row_r;
    col      = done_r ? '0 : load_col_r;
    rs_new   = ((col == '0) ? RS_W'(0) : rs_r) + RS_W'(in_element_value);
    last_col = (col + CFG_W'(1)) >= cols_r;
    last_row = (row + CFG_W'(1)) >= rows_r;

    tm1 = in_top_row - CFG_W'(1);
    lm1 = in_left_col - CFG_W'(1);
    ok  = done_r && (in_top_row != '0) && (in_left_col != '0) &&
          (in_top_row <= in_bottom_row) && (in_left_col <= in_right_col) &&
          (in_bottom_row <= rows_r) && (in_right_col <= cols_r);

    if (!in_op) begin
      q_cmd.kind        = CMD_LOAD;
      q_cmd.status      = (last_col && last_row) ? STAT_DONE : STAT_STORED;
      q_cmd.use_mask[0] = (row != '0);
      q_cmd.addr[0]     = tab_addr(row - CFG_W'(1), col);
      q_cmd.addr[1]     = tab_addr(row, col);
      q_cmd.rsum        = rs_new;
    end else begin
      q_cmd.kind     = ok ? CMD_QUERY : CMD_REJECT;
      q_cmd.status   = ok ? STAT_ANSWER : STAT_REJECT;
      q_cmd.use_mask = {(tm1 != '0) && (lm1 != '0), (lm1 != '0), (tm1 != '0), 1'b1};
      q_cmd.addr[0]  = tab_addr(in_bottom_row - CFG_W'(1), in_right_col - CFG_W'(1));
      q_cmd.addr[1]  = tab_addr(tm1 - CFG_W'(1), in_right_col - CFG_W'(1));
      q_cmd.addr[2]  = tab_addr(in_bottom_row - CFG_W'(1), lm1 - CFG_W'(1));
      q_cmd.addr[3]  = tab_addr(tm1 - CFG_W'(1), lm1 - CFG_W'(1));
    end

    if (q_push && !in_op) begin
      if (last_col) begin
        load_col_nxt = '0;
        rs_nxt       = '0;
        if (last_row) begin
          load_row_nxt = '0;
          done_nxt     = 1'b1;
        end else begin
          load_row_nxt = row + CFG_W'(1);
          done_nxt     = 1'b0;
        end
      end else begin
        load_col_nxt = col + CFG_W'(1);
        load_row_nxt = row;
        rs_nxt       = rs_new;
        done_nxt     = 1'b0;
      end
    end

    // any register write restarts loading
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_nxt = clamp_size(cfg_data, MAX_ROWS);
        REG_COLS: cols_nxt = clamp_size(cfg_data, MAX_COLS);
        default: ;
      endcase
      load_row_nxt = '0;
      load_col_nxt = '0;
      rs_nxt       = '0;
      done_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= CFG_ROWS_RST;
      cols_r     <= CFG_COLS_RST;
      load_row_r <= '0;
      load_col_r <= '0;
      rs_r       <= '0;
      done_r     <= 1'b0;
    end else begin
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      rs_r       <= rs_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

// File: design/satq_queue.sv
`timescale 1ns / 1ps
module satq_queue import satq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/satq_back.sv
`timescale 1ns / 1ps
module satq_back import satq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  cmd_t                    q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] out_rect_sum,
  output logic [1:0]              out_status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_r, state_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  cmd_t                    cmd_r, cmd_nxt;

  logic [SUM_W-1:0]        prefix_r [DEPTH];
  logic signed [SUM_W-1:0] rd_q_r;
  logic                    mem_re, mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic signed [SUM_W-1:0] mem_wdata;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_rect_sum_r;
  logic [1:0]              out_status_r;

  logic                    can_out, emit;
  logic signed [SUM_W-1:0] emit_sum;
  logic [1:0]              emit_stat;
  logic [1:0]              k;
  logic signed [SUM_W-1:0] term, sum_now;

  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_rect_sum_r;
  assign out_status   = out_status_r;
  assign can_out      = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = q_head.addr[0];
    mem_wdata = '0;
    emit      = 1'b0;
    emit_sum  = '0;
    emit_stat = q_head.status;

    // corner idx-1 arrives from the most recently issued read
    k       = idx_r[1:0] - 2'd1;
    term    = cmd_r.use_mask[k] ? rd_q_r : '0;
    sum_now = ((k == 2'd1) || (k == 2'd2)) ? acc_r - term : acc_r + term;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == CMD_REJECT) begin
            if (can_out) begin
              q_pop = 1'b1;
              emit  = 1'b1;
            end
          end else begin
            q_pop     = 1'b1;
            cmd_nxt   = q_head;
            mem_re    = 1'b1;
            idx_nxt   = 3'd1;
            acc_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        emit_stat = cmd_r.status;
        if (cmd_r.kind == CMD_LOAD) begin
          // write and report together, so hold while the output is full
          if (can_out) begin
            mem_we    = 1'b1;
            mem_addr  = cmd_r.addr[1];
            mem_wdata = term + SUM_W'(cmd_r.rsum);
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (idx_r == 3'd4) begin
          if (can_out) begin
            emit      = 1'b1;
            emit_sum  = sum_now;
            state_nxt = ST_IDLE;
          end
        end else begin
          acc_nxt  = sum_now;
          mem_re   = 1'b1;
          mem_addr = cmd_r.addr[idx_r[1:0]];
          idx_nxt  = idx_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cmd_r <= cmd_nxt;
    if (emit) begin
      out_rect_sum_r <= emit_sum;
      out_status_r   <= emit_stat;
    end
  end

  // single-port table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= prefix_r[mem_addr];
    end
  end

endmodule

// File: design/summed_area_table_query.sv
`timescale 1ns / 1ps
// Throughput is set by the single port of the prefix table memory (one read or
// write per cycle): a load takes one read and one write, a query four reads and
// a reject no table access.
// A two-entry queue lets requests be taken while the table unit is busy.
// Reset (synchronous, active low) restores sizes 4 x 5 and clears load progress;
// table contents are undefined until loaded.
module summed_area_table_query import satq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic [CFG_W-1:0]         in_top_row,
  input  logic [CFG_W-1:0]         in_left_col,
  input  logic [CFG_W-1:0]         in_bottom_row,
  input  logic [CFG_W-1:0]         in_right_col,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  out_rect_sum,
  output logic [1:0]               out_status
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  satq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_element_value (in_element_value),
    .in_top_row       (in_top_row),
    .in_left_col      (in_left_col),
    .in_bottom_row    (in_bottom_row),
    .in_right_col     (in_right_col),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  satq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  satq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rect_sum (out_rect_sum),
    .out_status   (out_status)
  );

endmodule
